/* hdl/vss_pkg.sv */
// Package for the voltage seven-segment scan block.
// Holds key codes, scaling constants and the segment pattern table.
// Depends on nothing; imported by the top level and its checker.
package vss_pkg;

	// Key port codes that change the channel choice
	localparam logic [7:0] KEY_PICK_ONE  = 8'h80;
	localparam logic [7:0] KEY_PICK_ZERO = 8'h40;

	// floor(sample * 244 / 100) == (sample * MV_RECIP) >> MV_SHIFT for 10-bit samples
	localparam int unsigned MV_SHIFT = 21;
	localparam logic [22:0] MV_RECIP = 23'd5117107;

	// Reciprocals for splitting the remainder into decimal digits
	localparam logic [5:0] HUND_RECIP = 6'd41;   // r < 1000 : (r * 41) >> 12
	localparam logic [7:0] TENS_RECIP = 8'd205;  // r < 100  : (r * 205) >> 11

	localparam logic [7:0] SEG_BLANK = 8'hFF;

	typedef logic [3:0] digit_t;
	typedef logic [1:0] pos_t;

	// Active-low pattern, point bit held off
	function automatic logic [7:0] seg_of(input digit_t d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

/* hdl/voltage_seven_segment_scan.sv */
// Voltage readout for a four-digit multiplexed seven-segment display.
// Pipeline of scaling and digit split, then a four-result digit serialiser.
// Depends on vss_pkg.

// Each accepted item carries the key port byte and two 10-bit samples. Key 0x80
// selects channel 1, key 0x40 selects channel 0, any other byte keeps the choice
// (reset picks channel 0); the item carrying the key already uses the new choice.
// The chosen sample is scaled to millivolts as floor(sample*244/100) (0..2496) and
// shown as four results, thousands first, each with an active-low segment pattern,
// its digit position, the channel used and a flag on the units digit. Throughput
// is set by the output serialiser: one digit per cycle while out_stall is low,
// and the next item loads as the units digit leaves. An item enters in any cycle
// in which the pipeline has room, so up to four items queue in the stages while a
// run is on the output; each passes stages 1 to 4 before the serialiser shows it.
module voltage_seven_segment_scan
	import vss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_pins,
	input  logic [9:0] sample_zero,
	input  logic [9:0] sample_one,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic [1:0] digit_position,
	output logic       channel_used,
	output logic       last_digit
);

	// Channel choice
	logic sel_q;
	logic sel_next;

	// Stage 1: chosen sample
	logic       valid_s1;
	logic [9:0] sample_s1;
	logic       chan_s1;

	// Stage 2: millivolts
	logic        valid_s2;
	logic [11:0] mv_s2;
	logic        chan_s2;

	// Stage 3: thousands, hundreds and the remainder below 1000
	logic       valid_s3;
	digit_t     thou_s3;
	digit_t     hund_s3;
	logic [9:0] rem_s3;
	logic       chan_s3;

	// Stage 4: thousands, hundreds and the remainder below 100
	logic       valid_s4;
	digit_t     thou_s4;
	digit_t     hund_s4;
	logic [6:0] rem_s4;
	logic       chan_s4;

	// Output serialiser
	logic   buf_valid_q;
	digit_t dig_q [4];
	logic   chan_q;
	pos_t   pos_q;

	// Advance enables, back to front
	logic take_out;
	logic load_buf;
	logic adv_s3;
	logic adv_s2;
	logic adv_s1;
	logic adv_in;

	// Combinational results of each stage
	logic [32:0] mv_prod;
	logic [11:0] mv_c;
	digit_t      thou_c;
	logic [11:0] rem1_wide;
	logic [15:0] hund_prod;
	digit_t      hund_c;
	logic [9:0]  rem2_wide;
	logic [14:0] tens_prod;
	digit_t      tens_c;
	logic [6:0]  units_wide;
	logic [9:0]  sel_sample;

	assign take_out = buf_valid_q && !out_stall;
	// Refill the serialiser when empty or as its units digit leaves
	assign load_buf = !buf_valid_q || (take_out && pos_q == 2'd3);
	assign adv_s3   = !valid_s4 || load_buf;
	assign adv_s2   = !valid_s3 || adv_s3;
	assign adv_s1   = !valid_s2 || adv_s2;
	assign adv_in   = !valid_s1 || adv_s1;
	assign in_stall = !adv_in;

	// Update the choice first, then pick the sample with it
	always_comb begin
		priority if (key_pins == KEY_PICK_ONE) begin
			sel_next = 1'b1;
		end else if (key_pins == KEY_PICK_ZERO) begin
			sel_next = 1'b0;
		end else begin
			sel_next = sel_q;
		end
		sel_sample = sel_next ? sample_one : sample_zero;
	end

	// Scale: one constant multiply, keep the top bits
	always_comb begin
		mv_prod = 33'(sample_s1) * 33'(MV_RECIP);
		mv_c    = mv_prod[MV_SHIFT +: 12];
	end

	// Thousands never exceed two; hundreds by reciprocal
	always_comb begin
		priority if (mv_s2 >= 12'd2000) begin
			thou_c = 4'd2;
		end else if (mv_s2 >= 12'd1000) begin
			thou_c = 4'd1;
		end else begin
			thou_c = 4'd0;
		end
		rem1_wide = mv_s2 - 12'(thou_c) * 12'd1000;
		hund_prod = 16'(rem1_wide[9:0]) * 16'(HUND_RECIP);
		hund_c    = hund_prod[15:12];
	end

	// Drop the hundreds from the remainder
	always_comb begin
		rem2_wide = rem_s3 - 10'(hund_s3) * 10'd100;
	end

	// Tens by reciprocal, units by what is left
	always_comb begin
		tens_prod  = 15'(rem_s4) * 15'(TENS_RECIP);
		tens_c     = tens_prod[14:11];
		units_wide = rem_s4 - 7'({tens_c, 3'b000}) - 7'({tens_c, 1'b0});
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			buf_valid_q <= 1'b0;
			pos_q       <= 2'd0;
		end else begin
			if (in_valid && adv_in) begin
				sel_q <= sel_next;
			end
			if (adv_in) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s2) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s3) begin
				valid_s4 <= valid_s3;
			end
			if (load_buf) begin
				buf_valid_q <= valid_s4;
				pos_q       <= 2'd0;
			end else if (take_out) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv_in && in_valid) begin
			sample_s1 <= sel_sample;
			chan_s1   <= sel_next;
		end
		if (adv_s1 && valid_s1) begin
			mv_s2   <= mv_c;
			chan_s2 <= chan_s1;
		end
		if (adv_s2 && valid_s2) begin
			thou_s3 <= thou_c;
			hund_s3 <= hund_c;
			rem_s3  <= rem1_wide[9:0];
			chan_s3 <= chan_s2;
		end
		if (adv_s3 && valid_s3) begin
			thou_s4 <= thou_s3;
			hund_s4 <= hund_s3;
			rem_s4  <= rem2_wide[6:0];
			chan_s4 <= chan_s3;
		end
		if (load_buf && valid_s4) begin
			dig_q[0] <= thou_s4;
			dig_q[1] <= hund_s4;
			dig_q[2] <= tens_c;
			dig_q[3] <= units_wide[3:0];
			chan_q   <= chan_s4;
		end
	end

	assign out_valid      = buf_valid_q;
	assign segments       = seg_of(dig_q[pos_q]);
	assign digit_position = pos_q;
	assign channel_used   = chan_q;
	assign last_digit     = (pos_q == 2'd3);

endmodule

/* hdl/vss_checker.sv */
// Port checker for voltage_seven_segment_scan, bound to the top level.
// Watches the result channel over time. Depends on vss_pkg.
module vss_checker
	import vss_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] segments,
	input logic [1:0] digit_position,
	input logic       channel_used,
	input logic       last_digit
);

	// A stalled item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segments)
			&& $stable(digit_position))
		else $error("stalled result item changed");

	// A run keeps going after each non-final digit, one position up
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_digit
			|=> out_valid && digit_position == $past(digit_position) + 2'd1)
		else $error("digit run broken or out of order");

	// The channel stays the same within one run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_digit |=> channel_used == $past(channel_used))
		else $error("channel changed within a run");

	// The units flag marks position three and the point stays off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_digit == (digit_position == 2'd3)) && segments[7])
		else $error("units flag or point bit wrong");

endmodule

bind voltage_seven_segment_scan vss_checker u_vss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.segments       (segments),
	.digit_position (digit_position),
	.channel_used   (channel_used),
	.last_digit     (last_digit)
);
